// ----- src/bpts_pkg.sv -----
package bpts_pkg;

	localparam int MS_W = 16;
	localparam int ACT_W = 3;
	localparam int PULSES_W = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int TIME_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 8;

	localparam logic [ACT_W-1:0] ACT_TICK = 3'd0;
	localparam logic [ACT_W-1:0] ACT_TONE_ON = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TONE_OFF = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TRAIN_ON = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TRAIN_OFF = 3'd4;

	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULSES = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PULSE_MS = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULSE_MS = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FINAL_PAUSE_MS = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_GAP_MS = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_LEVEL = 3'd5;

	localparam logic [PULSES_W-1:0] RST_MAX_PULSES = 8'd10;
	localparam logic [MS_W-1:0] RST_MIN_PULSE_MS = 16'd50;
	localparam logic [MS_W-1:0] RST_MAX_PULSE_MS = 16'd1000;
	localparam logic [MS_W-1:0] RST_MAX_FINAL_PAUSE_MS = 16'd5000;
	localparam logic [MS_W-1:0] RST_GAP_MS = 16'd100;
	localparam logic [MS_W-1:0] RST_DUTY_LEVEL = 16'd32768;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [MS_W-1:0] pulse_count;
		logic [MS_W-1:0] pulse_ms;
		logic [MS_W-1:0] final_pause_ms;
	} in_item_t;

	typedef struct packed {
		logic [MS_W-1:0] drive_level;
		logic accepted;
		logic train_busy;
		logic tone_busy;
		logic train_done;
	} out_item_t;

	typedef struct packed {
		logic [PULSES_W-1:0] max_pulses;
		logic [MS_W-1:0] min_pulse_ms;
		logic [MS_W-1:0] max_pulse_ms;
		logic [MS_W-1:0] max_final_pause_ms;
		logic [MS_W-1:0] gap_ms;
		logic [MS_W-1:0] duty_level;
	} cfg_t;

endpackage

// ----- src/bpts_cfg_regs.sv -----
module bpts_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bpts_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bpts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output bpts_pkg::cfg_t cfg
);

	bpts_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pulses <= bpts_pkg::RST_MAX_PULSES;
			cfg_q.min_pulse_ms <= bpts_pkg::RST_MIN_PULSE_MS;
			cfg_q.max_pulse_ms <= bpts_pkg::RST_MAX_PULSE_MS;
			cfg_q.max_final_pause_ms <= bpts_pkg::RST_MAX_FINAL_PAUSE_MS;
			cfg_q.gap_ms <= bpts_pkg::RST_GAP_MS;
			cfg_q.duty_level <= bpts_pkg::RST_DUTY_LEVEL;
		end else if (cfg_we) begin
			case (cfg_addr)
				bpts_pkg::CFG_MAX_PULSES: begin
					cfg_q.max_pulses <= cfg_wdata[bpts_pkg::PULSES_W-1:0];
				end
				bpts_pkg::CFG_MIN_PULSE_MS: begin
					cfg_q.min_pulse_ms <= cfg_wdata;
				end
				bpts_pkg::CFG_MAX_PULSE_MS: begin
					cfg_q.max_pulse_ms <= cfg_wdata;
				end
				bpts_pkg::CFG_MAX_FINAL_PAUSE_MS: begin
					cfg_q.max_final_pause_ms <= cfg_wdata;
				end
				bpts_pkg::CFG_GAP_MS: begin
					cfg_q.gap_ms <= cfg_wdata;
				end
				bpts_pkg::CFG_DUTY_LEVEL: begin
					cfg_q.duty_level <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/bpts_in_stage.sv -----
module bpts_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bpts_pkg::in_item_t in_item,
	input  logic take,
	output logic valid_s1,
	output bpts_pkg::in_item_t item_s1
);

	logic vld_s1;
	bpts_pkg::in_item_t itm_s1;

	assign in_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			itm_s1 <= in_item;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1 = itm_s1;

endmodule

// ----- src/bpts_core.sv -----
module bpts_core #(
	parameter int TIME_WIDTH = bpts_pkg::TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = bpts_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  bpts_pkg::in_item_t item_s1,
	output logic take,
	input  bpts_pkg::cfg_t cfg,
	output logic out_valid,
	input  logic out_ready,
	output bpts_pkg::out_item_t out_item
);

	localparam int MS_W = bpts_pkg::MS_W;
	localparam int WIDE = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic train_q, tone_q, drive_q, gap_q, fpause_q;
	logic [COUNT_WIDTH-1:0] beeps_q, tlen_q;
	logic [TIME_WIDTH-1:0] elapsed_q, blen_q, plen_q;

	logic n_train, n_tone, n_drive, n_gap, n_fpause;
	logic [COUNT_WIDTH-1:0] n_beeps, n_tlen;
	logic [TIME_WIDTH-1:0] n_elapsed, n_blen, n_plen;
	logic acc, done, adv;

	logic [MS_W-1:0] cnt_lo, cnt_hi, cnt_v;
	logic [MS_W-1:0] beep_hi, beep_v, pause_v;
	logic [WIDE-1:0] beep_w, pause_w;
	logic [COUNT_WIDTH-1:0] tlen_new;
	logic [TIME_WIDTH-1:0] blen_new, plen_new;

	logic out_valid_s2;
	bpts_pkg::out_item_t out_item_s2;

	assign take = valid_s1 && (!out_valid_s2 || out_ready);

	// Clamping of the start-train request against the configured limits.
	always_comb begin
		cnt_lo = (item_s1.pulse_count == '0) ? MS_W'(1) : item_s1.pulse_count;
		cnt_hi = (cfg.max_pulses == '0) ? MS_W'(1) : MS_W'(cfg.max_pulses);
		cnt_v = (cnt_lo > cnt_hi) ? cnt_hi : cnt_lo;
		tlen_new = (cnt_v > MS_W'(COUNT_MAX)) ? COUNT_MAX : cnt_v[COUNT_WIDTH-1:0];

		beep_hi = (cfg.max_pulse_ms < cfg.min_pulse_ms) ? cfg.min_pulse_ms
			: cfg.max_pulse_ms;
		beep_v = (item_s1.pulse_ms < cfg.min_pulse_ms) ? cfg.min_pulse_ms
			: item_s1.pulse_ms;
		beep_v = (beep_v > beep_hi) ? beep_hi : beep_v;
		beep_w = WIDE'(beep_v);
		blen_new = (beep_w > WIDE'(TIME_MAX)) ? TIME_MAX : beep_w[TIME_WIDTH-1:0];

		pause_v = (item_s1.final_pause_ms > cfg.max_final_pause_ms)
			? cfg.max_final_pause_ms : item_s1.final_pause_ms;
		pause_w = WIDE'(pause_v);
		plen_new = (pause_w > WIDE'(TIME_MAX)) ? TIME_MAX : pause_w[TIME_WIDTH-1:0];
	end

	always_comb begin
		n_train = train_q;
		n_tone = tone_q;
		n_drive = drive_q;
		n_gap = gap_q;
		n_fpause = fpause_q;
		n_beeps = beeps_q;
		n_tlen = tlen_q;
		n_elapsed = elapsed_q;
		n_blen = blen_q;
		n_plen = plen_q;
		acc = 1'b0;
		done = 1'b0;
		adv = 1'b0;

		case (item_s1.action)
			bpts_pkg::ACT_TICK: begin
				if (train_q) begin
					if (elapsed_q != TIME_MAX) begin
						n_elapsed = elapsed_q + TIME_WIDTH'(1);
					end
					adv = 1'b1;
				end
			end
			bpts_pkg::ACT_TONE_ON: begin
				n_train = 1'b0;
				n_gap = 1'b0;
				n_fpause = 1'b0;
				n_tone = 1'b1;
				n_drive = 1'b1;
			end
			bpts_pkg::ACT_TONE_OFF: begin
				if (tone_q) begin
					n_tone = 1'b0;
					n_drive = 1'b0;
				end
			end
			bpts_pkg::ACT_TRAIN_ON: begin
				if (!train_q && !tone_q) begin
					acc = 1'b1;
					n_train = 1'b1;
					n_tlen = tlen_new;
					n_blen = blen_new;
					n_plen = plen_new;
					n_beeps = '0;
					n_elapsed = '0;
					n_gap = 1'b0;
					n_fpause = 1'b0;
					n_drive = 1'b1;
					adv = 1'b1;
				end
			end
			bpts_pkg::ACT_TRAIN_OFF: begin
				if (train_q) begin
					n_train = 1'b0;
					n_gap = 1'b0;
					n_fpause = 1'b0;
					n_drive = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// At most one phase change per item.
		if (adv) begin
			if (n_fpause) begin
				if (n_elapsed >= n_plen) begin
					n_train = 1'b0;
					n_gap = 1'b0;
					n_fpause = 1'b0;
					done = 1'b1;
				end
			end else if (!n_gap) begin
				if (n_elapsed >= n_blen) begin
					n_drive = 1'b0;
					n_gap = 1'b1;
					n_elapsed = '0;
					n_beeps = n_beeps + COUNT_WIDTH'(1);
				end
			end else if (WIDE'(n_elapsed) >= WIDE'(cfg.gap_ms)) begin
				if (n_beeps == n_tlen) begin
					if (n_plen == '0) begin
						n_train = 1'b0;
						n_gap = 1'b0;
						n_fpause = 1'b0;
						done = 1'b1;
					end else begin
						n_fpause = 1'b1;
						n_elapsed = '0;
					end
				end else begin
					n_drive = 1'b1;
					n_gap = 1'b0;
					n_elapsed = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_q <= 1'b0;
			tone_q <= 1'b0;
			drive_q <= 1'b0;
			gap_q <= 1'b0;
			fpause_q <= 1'b0;
			beeps_q <= '0;
			tlen_q <= '0;
			elapsed_q <= '0;
			blen_q <= '0;
			plen_q <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			out_valid_s2 <= take || (out_valid_s2 && !out_ready);
			if (take) begin
				train_q <= n_train;
				tone_q <= n_tone;
				drive_q <= n_drive;
				gap_q <= n_gap;
				fpause_q <= n_fpause;
				beeps_q <= n_beeps;
				tlen_q <= n_tlen;
				elapsed_q <= n_elapsed;
				blen_q <= n_blen;
				plen_q <= n_plen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_s2.drive_level <= n_drive ? cfg.duty_level : '0;
			out_item_s2.accepted <= acc;
			out_item_s2.train_busy <= n_train;
			out_item_s2.tone_busy <= n_tone;
			out_item_s2.train_done <= done;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_item = out_item_s2;

	a_tone_train_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(train_q && tone_q))
		else $error("tone and train active together");

	a_gap_in_train: assert property (@(posedge clk) disable iff (!arst_n)
		(gap_q || fpause_q) |-> (train_q && gap_q && !drive_q))
		else $error("gap or final pause outside a silent train");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && out_item_s2.train_done)
			|-> (!out_item_s2.train_busy && !out_item_s2.accepted))
		else $error("finished train still busy or just accepted");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && out_item_s2.accepted)
			|-> (out_item_s2.train_busy && !out_item_s2.tone_busy))
		else $error("accepted start without a running train");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(take) |-> ($stable(train_q) && $stable(elapsed_q) && $stable(beeps_q)))
		else $error("state changed without an item");

endmodule

// ----- src/beeper_pulse_train_sequencer.sv -----
// Beeper pulse-train sequencer. Each input item is one event (millisecond tick, tone
// start or stop, train start or stop) and produces exactly one result item with the
// buzzer drive level and status flags after that event. The block takes one item per
// clock while its results are taken. A result is presented after its item is accepted:
// the item waits in the input register, and the sequencer state and the result register
// are loaded together when the core takes the item. A result that is not taken holds the
// input register, which then holds off the next item. Configuration writes take effect at
// the next edge and must only be made while no item is in flight.
module beeper_pulse_train_sequencer #(
	parameter int TIME_WIDTH = bpts_pkg::TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = bpts_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bpts_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bpts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  bpts_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output bpts_pkg::out_item_t out_item
);

	bpts_pkg::cfg_t cfg;
	bpts_pkg::in_item_t item_s1;
	logic valid_s1;
	logic take;

	bpts_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	bpts_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.take(take),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	bpts_core #(
		.TIME_WIDTH(TIME_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.take(take),
		.cfg(cfg),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

// ----- tb/bpts_result_checker.sv -----
module bpts_result_checker
	import bpts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_ready,
	input  in_item_t in_item,
	input  logic out_valid,
	input  logic out_ready,
	input  out_item_t out_item,
	output int fail_count,
	output int waiting,
	output int checked,
	output int trains_done
);

	localparam logic [MS_W-1:0] ELAPSED_CAP = '1;

	cfg_t regs;
	logic train_on, tone_on, buzz_on, in_gap, in_pause;
	logic [PULSES_W-1:0] beeps_done, train_len;
	logic [MS_W-1:0] elapsed, beep_len, pause_len;
	out_item_t pending_results[$];
	int errors, n_checked, n_trains;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 50) begin
			$display("MISMATCH at result %0d: %s", n_checked, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [MS_W-1:0] got,
			input logic [MS_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (hi < lo) hi = lo;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic void finish_train();
		train_on = 1'b0;
		in_gap = 1'b0;
		in_pause = 1'b0;
	endfunction

	// One phase transition at most; returns 1 when the train has just ended.
	function automatic logic phase_step();
		if (in_pause) begin
			if (elapsed >= pause_len) begin
				finish_train();
				return 1'b1;
			end
			return 1'b0;
		end
		if (!in_gap) begin
			if (elapsed >= beep_len) begin
				buzz_on = 1'b0;
				in_gap = 1'b1;
				elapsed = '0;
				beeps_done = beeps_done + 1'b1;
			end
			return 1'b0;
		end
		if (elapsed >= regs.gap_ms) begin
			if (beeps_done == train_len) begin
				if (pause_len == '0) begin
					finish_train();
					return 1'b1;
				end
				in_pause = 1'b1;
				elapsed = '0;
			end else begin
				buzz_on = 1'b1;
				in_gap = 1'b0;
				elapsed = '0;
			end
		end
		return 1'b0;
	endfunction

	function automatic out_item_t predict_beeper_event(in_item_t it);
		out_item_t r;
		logic took, ended;
		took = 1'b0;
		ended = 1'b0;
		case (it.action)
		ACT_TICK: begin
			if (train_on) begin
				if (elapsed != ELAPSED_CAP) elapsed = elapsed + 1'b1;
				ended = phase_step();
			end
		end
		ACT_TONE_ON: begin
			finish_train();
			tone_on = 1'b1;
			buzz_on = 1'b1;
		end
		ACT_TONE_OFF: begin
			if (tone_on) begin
				tone_on = 1'b0;
				buzz_on = 1'b0;
			end
		end
		ACT_TRAIN_ON: begin
			if (!train_on && !tone_on) begin
				took = 1'b1;
				train_on = 1'b1;
				train_len = PULSES_W'(clamp_to(32'(it.pulse_count), 32'd1,
					32'(regs.max_pulses)));
				beep_len = MS_W'(clamp_to(32'(it.pulse_ms), 32'(regs.min_pulse_ms),
					32'(regs.max_pulse_ms)));
				pause_len = MS_W'(clamp_to(32'(it.final_pause_ms), 32'd0,
					32'(regs.max_final_pause_ms)));
				beeps_done = '0;
				elapsed = '0;
				in_gap = 1'b0;
				in_pause = 1'b0;
				buzz_on = 1'b1;
				ended = phase_step();
			end
		end
		ACT_TRAIN_OFF: begin
			if (train_on) begin
				finish_train();
				buzz_on = 1'b0;
			end
		end
		default: ;
		endcase
		r.drive_level = buzz_on ? regs.duty_level : '0;
		r.accepted = took;
		r.train_busy = train_on;
		r.tone_busy = tone_on;
		r.train_done = ended;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want, guess;
		if (!arst_n) begin
			regs = '{max_pulses: RST_MAX_PULSES, min_pulse_ms: RST_MIN_PULSE_MS,
				max_pulse_ms: RST_MAX_PULSE_MS, max_final_pause_ms: RST_MAX_FINAL_PAUSE_MS,
				gap_ms: RST_GAP_MS, duty_level: RST_DUTY_LEVEL};
			{train_on, tone_on, buzz_on, in_gap, in_pause} = '0;
			beeps_done = '0;
			train_len = '0;
			elapsed = '0;
			beep_len = '0;
			pause_len = '0;
			pending_results.delete();
			errors = 0;
			n_checked = 0;
			n_trains = 0;
			fail_count <= 0;
			waiting <= 0;
			checked <= 0;
			trains_done <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
				CFG_MAX_PULSES: regs.max_pulses = cfg_wdata[PULSES_W-1:0];
				CFG_MIN_PULSE_MS: regs.min_pulse_ms = cfg_wdata;
				CFG_MAX_PULSE_MS: regs.max_pulse_ms = cfg_wdata;
				CFG_MAX_FINAL_PAUSE_MS: regs.max_final_pause_ms = cfg_wdata;
				CFG_GAP_MS: regs.gap_ms = cfg_wdata;
				CFG_DUTY_LEVEL: regs.duty_level = cfg_wdata;
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result item arrived with nothing expected");
				end else begin
					want = pending_results.pop_front();
					check_field("drive_level", out_item.drive_level, want.drive_level);
					check_field("accepted", MS_W'(out_item.accepted), MS_W'(want.accepted));
					check_field("train_busy", MS_W'(out_item.train_busy),
						MS_W'(want.train_busy));
					check_field("tone_busy", MS_W'(out_item.tone_busy),
						MS_W'(want.tone_busy));
					check_field("train_done", MS_W'(out_item.train_done),
						MS_W'(want.train_done));
					n_checked++;
				end
			end
			if (in_valid && in_ready) begin
				guess = predict_beeper_event(in_item);
				if (guess.train_done) n_trains++;
				pending_results.push_back(guess);
			end
			fail_count <= errors;
			waiting <= pending_results.size();
			checked <= n_checked;
			trains_done <= n_trains;
		end
	end

endmodule

// ----- tb/beeper_pulse_train_sequencer_test.sv -----
module beeper_pulse_train_sequencer_test;
	import bpts_pkg::*;

	typedef enum {SET_SHORT, SET_INVERTED, SET_FLOOR, SET_CEILING, SET_WIDE, SET_LONG_TRAIN}
		setting_kind_t;
	typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	in_item_t in_item = '0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid;
	out_item_t out_item;

	int fail_count, waiting, checked, trains_done;
	int sent = 0;
	int settings = 0;
	int burst_left = 0;
	ready_mode_t stall_mode = RDY_ALWAYS;
	int stall_left = 0;
	int beat = 0;

	beeper_pulse_train_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	bpts_result_checker result_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.fail_count(fail_count),
		.waiting(waiting),
		.checked(checked),
		.trains_done(trains_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = ready_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		beat++;
		case (stall_mode)
		RDY_ALWAYS: out_ready <= 1'b1;
		RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
		RDY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
		default: out_ready <= (beat % 5 == 0);
		endcase
	end

	function automatic in_item_t make_event(logic [ACT_W-1:0] act, logic [MS_W-1:0] cnt,
			logic [MS_W-1:0] ms, logic [MS_W-1:0] pause);
		in_item_t it;
		it.action = act;
		it.pulse_count = cnt;
		it.pulse_ms = ms;
		it.final_pause_ms = pause;
		return it;
	endfunction

	function automatic logic [MS_W-1:0] pick_field();
		case ($urandom_range(0, 4))
		0: return MS_W'($urandom_range(0, 8));
		1: return MS_W'($urandom_range(0, 300));
		2: return '1;
		3: return '0;
		default: return MS_W'($urandom);
		endcase
	endfunction

	function automatic in_item_t noise_event();
		return make_event(ACT_W'($urandom_range(0, 7)), pick_field(), pick_field(), pick_field());
	endfunction

	task automatic push_event(input in_item_t it);
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input cfg_t c);
		drain();
		write_reg(CFG_MAX_PULSES, CFG_DATA_W'(c.max_pulses));
		write_reg(CFG_MIN_PULSE_MS, c.min_pulse_ms);
		write_reg(CFG_MAX_PULSE_MS, c.max_pulse_ms);
		write_reg(CFG_MAX_FINAL_PAUSE_MS, c.max_final_pause_ms);
		write_reg(CFG_GAP_MS, c.gap_ms);
		write_reg(CFG_DUTY_LEVEL, c.duty_level);
		settings++;
	endtask

	task automatic run_phase(input setting_kind_t kind, input int count);
		cfg_t c;
		int stop_at, n;
		case (kind)
		SET_SHORT: begin
			c.max_pulses = PULSES_W'($urandom_range(1, 5));
			c.min_pulse_ms = MS_W'($urandom_range(1, 4));
			c.max_pulse_ms = MS_W'(c.min_pulse_ms + $urandom_range(0, 5));
			c.max_final_pause_ms = MS_W'($urandom_range(0, 8));
			c.gap_ms = MS_W'($urandom_range(1, 6));
			c.duty_level = MS_W'($urandom);
		end
		SET_INVERTED: begin
			c.max_pulses = PULSES_W'($urandom_range(1, 4));
			c.min_pulse_ms = MS_W'($urandom_range(2, 6));
			c.max_pulse_ms = MS_W'($urandom_range(1, c.min_pulse_ms - 1));
			c.max_final_pause_ms = MS_W'($urandom_range(0, 5));
			c.gap_ms = MS_W'($urandom_range(1, 4));
			c.duty_level = MS_W'($urandom);
		end
		SET_FLOOR: c = '{max_pulses: 8'd1, min_pulse_ms: 16'd1, max_pulse_ms: 16'd1,
			max_final_pause_ms: 16'd0, gap_ms: 16'd1, duty_level: 16'd0};
		SET_CEILING: c = '{max_pulses: '1, min_pulse_ms: '1, max_pulse_ms: '1,
			max_final_pause_ms: '1, gap_ms: '1, duty_level: '1};
		SET_LONG_TRAIN: c = '{max_pulses: '1, min_pulse_ms: 16'd1, max_pulse_ms: 16'd3,
			max_final_pause_ms: 16'd3, gap_ms: 16'd1, duty_level: '1};
		default: begin
			c.max_pulses = PULSES_W'($urandom_range(1, 255));
			c.min_pulse_ms = MS_W'($urandom_range(1, 65535));
			c.max_pulse_ms = MS_W'($urandom_range(1, 65535));
			c.max_final_pause_ms = MS_W'($urandom);
			c.gap_ms = MS_W'($urandom_range(1, 65535));
			c.duty_level = MS_W'($urandom);
		end
		endcase
		apply_setting(c);
		stop_at = sent + count;
		while (sent < stop_at) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				// A train start followed by a run of ticks, with the odd stray event.
				push_event(make_event(ACT_TRAIN_ON, pick_field(), pick_field(), pick_field()));
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
					: $urandom_range(1, 60);
				repeat (n) begin
					if ($urandom_range(0, 99) < 3) push_event(noise_event());
					else push_event(make_event(ACT_TICK, MS_W'($urandom), MS_W'($urandom),
						MS_W'($urandom)));
				end
			end
			6: begin
				push_event(make_event(ACT_TONE_ON, MS_W'($urandom), MS_W'($urandom),
					MS_W'($urandom)));
				repeat ($urandom_range(1, 10)) begin
					push_event(make_event(ACT_TICK, MS_W'($urandom), MS_W'($urandom),
						MS_W'($urandom)));
				end
				push_event(make_event(ACT_TRAIN_ON, pick_field(), pick_field(), pick_field()));
				push_event(make_event(ACT_TONE_OFF, MS_W'($urandom), MS_W'($urandom),
					MS_W'($urandom)));
			end
			default: push_event(noise_event());
			endcase
		end
	endtask

	initial begin
		setting_kind_t plan[10];
		plan = '{SET_SHORT, SET_FLOOR, SET_SHORT, SET_INVERTED, SET_CEILING, SET_LONG_TRAIN,
			SET_SHORT, SET_WIDE, SET_INVERTED, SET_SHORT};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle events, stops with nothing running and the unused action codes.
		push_event(make_event(ACT_TICK, '0, '0, '0));
		push_event(make_event(ACT_TONE_OFF, '1, '1, '1));
		push_event(make_event(ACT_TRAIN_OFF, '0, '0, '0));
		for (int a = 5; a < 8; a++) push_event(make_event(ACT_W'(a), '1, '0, '1));
		// Tone on twice, a train refused under the tone, a train stop that leaves it alone.
		push_event(make_event(ACT_TONE_ON, '0, '0, '0));
		push_event(make_event(ACT_TONE_ON, '1, '1, '1));
		push_event(make_event(ACT_TRAIN_ON, 16'd1, 16'd100, '0));
		push_event(make_event(ACT_TRAIN_OFF, '0, '0, '0));
		push_event(make_event(ACT_TONE_OFF, '0, '0, '0));
		// Clamped start, refused second start, then a tone cancels the train.
		push_event(make_event(ACT_TRAIN_ON, '0, '0, '1));
		push_event(make_event(ACT_TRAIN_ON, '1, '1, '1));
		push_event(make_event(ACT_TICK, '1, '1, '1));
		push_event(make_event(ACT_TONE_ON, '0, '0, '0));
		push_event(make_event(ACT_TONE_OFF, '0, '0, '0));
		push_event(make_event(ACT_TRAIN_ON, '1, '1, '1));
		push_event(make_event(ACT_TRAIN_OFF, '1, '1, '1));
		// Tight limits so trains run to the end, with and without a final pause.
		apply_setting('{max_pulses: 8'd2, min_pulse_ms: 16'd1, max_pulse_ms: 16'd1,
			max_final_pause_ms: 16'd2, gap_ms: 16'd1, duty_level: 16'hA5A5});
		push_event(make_event(ACT_TRAIN_ON, '1, '0, '1));
		repeat (7) push_event(make_event(ACT_TICK, '0, '0, '0));
		push_event(make_event(ACT_TRAIN_ON, '0, '0, '0));
		repeat (2) push_event(make_event(ACT_TICK, '0, '0, '0));

		foreach (plan[i]) run_phase(plan[i], 80);

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d items under %0d register settings after reset.", sent, settings);
		$display("Compared %0d results; %0d trains ran to completion.", checked, trains_done);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results still outstanding.", waiting);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- beeper_pulse_train_sequencer.f -----
src/bpts_pkg.sv
src/bpts_cfg_regs.sv
src/bpts_in_stage.sv
src/bpts_core.sv
src/beeper_pulse_train_sequencer.sv
tb/bpts_result_checker.sv
tb/beeper_pulse_train_sequencer_test.sv
